// ===== sv/fsmr_pkg.sv =====
// fsmr_pkg: shared types and constants of the framed serial message receiver.
// No dependencies; imported by the core, the top level, the checker and the testbench.
package fsmr_pkg;

    // Link control codes
    localparam logic [7:0] CODE_STX       = 8'h02;
    localparam logic [7:0] CODE_ETX       = 8'h03;
    localparam logic [7:0] CODE_EOT       = 8'h04;
    localparam logic [7:0] CODE_ENQ       = 8'h05;
    localparam logic [7:0] CODE_PRINT_MIN = 8'h20;

    // Item kinds
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Reply codes
    localparam logic [1:0] TX_NONE = 2'd0;
    localparam logic [1:0] TX_ACK  = 2'd1;
    localparam logic [1:0] TX_NAK  = 2'd2;

    // Message status codes
    localparam logic [2:0] ST_RUNNING  = 3'd0;
    localparam logic [2:0] ST_ACCEPTED = 3'd1;
    localparam logic [2:0] ST_REJECTED = 3'd2;
    localparam logic [2:0] ST_TIMEOUT  = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] REG_CHECK_ENABLED  = 2'd0;
    localparam logic [1:0] REG_TWO_CHAR_CHECK = 2'd1;
    localparam logic [1:0] REG_INCLUDE_STX    = 2'd2;
    localparam logic [1:0] REG_WAIT_LIMIT     = 2'd3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int MSG_LEN_W   = 9;
    localparam int OUT_DATA_W  = 32;

    localparam logic [15:0] WAIT_LIMIT_RST = 16'd300;

    typedef struct packed {
        logic        check_enabled;
        logic        two_char_check;
        logic        include_stx;
        logic [15:0] wait_limit;
    } t_cfg;

    typedef struct packed {
        logic [1:0]           tx_code;
        logic                 data_valid;
        logic [7:0]           data_byte;
        logic [7:0]           data_index;
        logic                 frame_start;
        logic [2:0]           status;
        logic [MSG_LEN_W-1:0] message_length;
    } t_result;

endpackage

// ===== sv/framed_serial_message_receiver_top.sv =====
// framed_serial_message_receiver_top: ENQ/STX..ETX/check/EOT link receiver.
// Depends on fsmr_pkg and fsmr_core.
//
//   channel   direction  content
//   s_axis    in         tuser = req_type, tdata = rx_byte
//   m_axis    out        tuser = data_valid, tdata = reply, text byte, index,
//                        frame start, status, message length
//   cfg       in         register index and write data, always ready
//
// One item per clock sustained while m_axis is not stalled; each item passes the
// input register, then the step logic into the result register.
// The state update in fsmr_core, one step per item, sets that rate.
// Reset (i_rst_n low, synchronous) empties both registers, clears the message
// state and loads the register defaults. A stall on m_axis holds the result;
// the input register still takes one more item and then backpressures s_axis.
module framed_serial_message_receiver_top #(
    parameter int MAX_FRAME_BYTES = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // [7:0] rx_byte
    input  logic                                s_axis_tuser,  // [0] req_type
    // master stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [1:0] tx_code, [9:2] data_byte, [17:10] data_index, [18] frame_start,
    // [21:19] status, [30:22] message_length, [31] zero
    output logic [fsmr_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tuser,  // [0] data_valid
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [fsmr_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [fsmr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import fsmr_pkg::*;

    t_cfg       r_cfg;
    logic       r_in_valid;
    logic       r_in_req;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    t_result    step_res;
    logic       out_free;
    logic       step;

    // result register can take a new value when empty or being drained
    assign out_free      = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || step;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.check_enabled  <= 1'b1;
            r_cfg.two_char_check <= 1'b1;
            r_cfg.include_stx    <= 1'b1;
            r_cfg.wait_limit     <= WAIT_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_CHECK_ENABLED:  r_cfg.check_enabled  <= i_cfg_data[0];
                REG_TWO_CHAR_CHECK: r_cfg.two_char_check <= i_cfg_data[0];
                REG_INCLUDE_STX:    r_cfg.include_stx    <= i_cfg_data[0];
                REG_WAIT_LIMIT:     r_cfg.wait_limit     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_req  <= s_axis_tuser;
            r_in_byte <= s_axis_tdata;
        end
    end

    fsmr_core #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_req_type (r_in_req),
        .i_rx_byte  (r_in_byte),
        .i_cfg      (r_cfg),
        .o_result   (step_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= step_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.data_valid;
    assign m_axis_tdata  = {1'b0, r_out.message_length, r_out.status, r_out.frame_start,
                            r_out.data_index, r_out.data_byte, r_out.tx_code};

endmodule

// ===== sv/fsmr_core.sv =====
// fsmr_core: message state registers and the one-item protocol step.
// Depends on fsmr_pkg (codes, t_cfg, t_result).
module fsmr_core #(
    parameter int MAX_FRAME_BYTES = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_req_type,
    input  logic [7:0]       i_rx_byte,
    input  fsmr_pkg::t_cfg   i_cfg,
    output fsmr_pkg::t_result o_result
);
    import fsmr_pkg::*;

    localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [CW-1:0] MaxCount = CW'(MAX_FRAME_BYTES);

    // {ok, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, b[3:0]};
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

    logic          r_session_open,   n_session_open;
    logic          r_in_check,       n_in_check;
    logic [2:0]    r_chars_seen,     n_chars_seen;
    logic [CW-1:0] r_text_count,     n_text_count;
    logic [15:0]   r_sum,            n_sum;
    logic [15:0]   r_rx_check,       n_rx_check;
    logic          r_char_bad,       n_char_bad;
    logic          r_frame_good,     n_frame_good;
    logic [15:0]   r_idle,           n_idle;

    logic [CW+8:0] count_ext;
    logic [4:0]    hex;
    logic [15:0]   fold_b;
    logic [15:0]   fold_sum;
    logic [15:0]   chk_mask;
    logic [2:0]    need;
    logic          clear;
    t_result       res;

    always_comb begin
        n_session_open = r_session_open;
        n_in_check     = r_in_check;
        n_chars_seen   = r_chars_seen;
        n_text_count   = r_text_count;
        n_sum          = r_sum;
        n_rx_check     = r_rx_check;
        n_char_bad     = r_char_bad;
        n_frame_good   = r_frame_good;
        n_idle         = r_idle;
        clear          = 1'b0;
        res            = '0;
        res.tx_code    = TX_NONE;
        res.status     = ST_RUNNING;
        count_ext      = {9'd0, r_text_count};
        hex            = hex_decode(i_rx_byte);
        need           = i_cfg.two_char_check ? 3'd2 : 3'd4;
        chk_mask       = i_cfg.two_char_check ? 16'h00FF : 16'hFFFF;
        // ETX folds its own code, text bytes fold themselves
        fold_b         = (i_rx_byte == CODE_ETX) ? {8'd0, CODE_ETX} : {8'd0, i_rx_byte};
        fold_sum       = i_cfg.two_char_check ? (r_sum ^ fold_b) : (r_sum + fold_b);

        if (i_req_type == REQ_TICK) begin
            n_idle = (r_idle == 16'hFFFF) ? r_idle : r_idle + 16'd1;
            if (n_idle >= i_cfg.wait_limit) begin
                res.status = ST_TIMEOUT;
                clear      = 1'b1;
            end
        end else begin
            n_idle = '0;
            if (i_rx_byte == CODE_ENQ) begin
                if (!r_session_open) begin
                    res.tx_code    = TX_ACK;
                    n_session_open = 1'b1;
                end
            end else if (i_rx_byte == CODE_STX) begin
                n_in_check      = 1'b0;
                n_chars_seen    = '0;
                n_text_count    = '0;
                n_rx_check      = '0;
                n_char_bad      = 1'b0;
                n_sum           = i_cfg.include_stx ? {8'd0, CODE_STX} : 16'd0;
                res.frame_start = 1'b1;
            end else if (i_rx_byte == CODE_ETX) begin
                n_sum = fold_sum;
                if (i_cfg.check_enabled) begin
                    n_in_check   = 1'b1;
                    n_chars_seen = '0;
                    n_rx_check   = '0;
                    n_char_bad   = 1'b0;
                end else begin
                    res.tx_code  = TX_ACK;
                    n_frame_good = 1'b1;
                end
            end else if (i_rx_byte == CODE_EOT) begin
                if (r_frame_good && r_session_open) begin
                    res.status         = ST_ACCEPTED;
                    res.message_length = count_ext[MSG_LEN_W-1:0];
                end else begin
                    res.status = ST_REJECTED;
                end
                clear = 1'b1;
            end else if (r_in_check) begin
                n_char_bad   = r_char_bad | ~hex[4];
                n_rx_check   = {r_rx_check[11:0], hex[3:0]};
                n_chars_seen = r_chars_seen + 3'd1;
                if (n_chars_seen >= need) begin
                    n_in_check = 1'b0;
                    if (!n_char_bad && ((r_sum & chk_mask) == (n_rx_check & chk_mask))) begin
                        res.tx_code  = TX_ACK;
                        n_frame_good = 1'b1;
                    end else begin
                        res.tx_code  = TX_NAK;
                        n_chars_seen = '0;
                        n_text_count = '0;
                    end
                end
            end else if (i_rx_byte >= CODE_PRINT_MIN) begin
                n_sum          = fold_sum;
                res.data_valid = 1'b1;
                res.data_byte  = i_rx_byte;
                res.data_index = count_ext[7:0];
                n_text_count   = r_text_count + CW'(1);
            end
            // frame too long ends the message
            if (res.status == ST_RUNNING && n_text_count >= MaxCount) begin
                res.status = ST_OVERFLOW;
                clear      = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_session_open <= 1'b0;
            r_in_check     <= 1'b0;
            r_chars_seen   <= '0;
            r_text_count   <= '0;
            r_sum          <= '0;
            r_rx_check     <= '0;
            r_char_bad     <= 1'b0;
            r_frame_good   <= 1'b0;
            r_idle         <= '0;
        end else if (i_step) begin
            if (clear) begin
                r_session_open <= 1'b0;
                r_in_check     <= 1'b0;
                r_chars_seen   <= '0;
                r_text_count   <= '0;
                r_sum          <= '0;
                r_rx_check     <= '0;
                r_char_bad     <= 1'b0;
                r_frame_good   <= 1'b0;
                r_idle         <= '0;
            end else begin
                r_session_open <= n_session_open;
                r_in_check     <= n_in_check;
                r_chars_seen   <= n_chars_seen;
                r_text_count   <= n_text_count;
                r_sum          <= n_sum;
                r_rx_check     <= n_rx_check;
                r_char_bad     <= n_char_bad;
                r_frame_good   <= n_frame_good;
                r_idle         <= n_idle;
            end
        end
    end

    assign o_result = res;

endmodule

// ===== sv/fsmr_checker.sv =====
// fsmr_checker: port-level assertions for the framed serial message receiver.
// Depends on fsmr_pkg; bound to framed_serial_message_receiver_top.
module fsmr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    import fsmr_pkg::*;

    logic [1:0]           tx;
    logic [7:0]           dbyte;
    logic [7:0]           didx;
    logic                 fstart;
    logic [2:0]           st;
    logic [MSG_LEN_W-1:0] mlen;

    assign tx     = m_axis_tdata[1:0];
    assign dbyte  = m_axis_tdata[9:2];
    assign didx   = m_axis_tdata[17:10];
    assign fstart = m_axis_tdata[18];
    assign st     = m_axis_tdata[21:19];
    assign mlen   = m_axis_tdata[30:22];

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // no text byte: byte and index are zero
    a_text_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> dbyte == 8'd0 && didx == 8'd0)
        else $error("text fields set without data_valid");

    // length only reported on an accepted message
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && st != ST_ACCEPTED |-> mlen == '0)
        else $error("message length outside accepted status");

    // a reply never coincides with the end of a message or with text
    a_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && tx != TX_NONE |-> st == ST_RUNNING && !m_axis_tuser)
        else $error("reply combined with message end or text");

    // STX item carries nothing else
    a_stx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && fstart |-> st == ST_RUNNING && !m_axis_tuser && tx == TX_NONE)
        else $error("frame start combined with other events");

endmodule

bind framed_serial_message_receiver_top fsmr_checker u_fsmr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== test/tb.sv =====
// tb: self-checking testbench for framed_serial_message_receiver_top.
// Depends on fsmr_pkg and the receiver RTL; drives random link traffic with
// stalls on both streams and checks every reply against a built-in predictor.
module tb;
    import fsmr_pkg::*;

    localparam int MAX_FRAME   = 256;
    localparam int N_DIR       = 25;
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 250;
    localparam int SINK_HOLD   = 300;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic       kind;
        logic [7:0] val;
    } t_link_item;

    // directed row: item, plus a hand-typed reply where one is obvious
    typedef struct packed {
        logic       kind;
        logic [7:0] val;
        logic       typed;
        logic [1:0] tx;
        logic [2:0] st;
        logic [8:0] len;
    } t_dir_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = 8'h00;
    logic                   s_axis_tuser = REQ_BYTE;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    always #4 i_clk = ~i_clk;

    framed_serial_message_receiver_top #(
        .MAX_FRAME_BYTES(MAX_FRAME)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // predictor copy of the registers (reset values)
    logic        cfg_check_en   = 1'b1;
    logic        cfg_two_char   = 1'b1;
    logic        cfg_seed_stx   = 1'b1;
    logic [15:0] cfg_wait_limit = WAIT_LIMIT_RST;

    // predictor copy of the message state
    logic        sess_open;
    logic        chk_phase;
    logic [2:0]  chk_seen;
    logic [8:0]  txt_cnt;
    logic [15:0] run_sum;
    logic [15:0] rx_check;
    logic        chk_bad;
    logic        frm_good;
    logic [15:0] tick_run;

    t_result     outcome_q[$];
    t_link_item  plan_q[$];
    t_dir_row    dir_rows [N_DIR];
    int          error_count = 0;
    int          results_seen = 0;
    int          phase_items = 0;
    int          quiet_cycles = 0;
    logic        src_calm = 1'b0;
    logic        snk_calm = 1'b0;
    logic        sink_hold_req = 1'b0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void drop_message();
        sess_open = 1'b0;
        chk_phase = 1'b0;
        chk_seen  = '0;
        txt_cnt   = '0;
        run_sum   = '0;
        rx_check  = '0;
        chk_bad   = 1'b0;
        frm_good  = 1'b0;
        tick_run  = '0;
    endfunction

    // XOR in two-char mode, 16-bit add in four-char mode
    function automatic logic [15:0] sum_next(logic [15:0] s, logic [7:0] b);
        return cfg_two_char ? (s ^ {8'h00, b}) : (s + {8'h00, b});
    endfunction

    function automatic t_result predict_reply(logic kind, logic [7:0] b);
        t_result     r;
        logic [3:0]  nib;
        logic [2:0]  need;
        logic [15:0] mask;
        r = '0;
        if (kind == REQ_TICK) begin
            if (tick_run != 16'hFFFF) tick_run = tick_run + 16'd1;
            if (tick_run >= cfg_wait_limit) begin
                r.status = ST_TIMEOUT;
                drop_message();
            end
        end else begin
            tick_run = '0;
            if (b == CODE_ENQ) begin
                // only the first ENQ of a message is answered
                if (!sess_open) begin
                    r.tx_code = TX_ACK;
                    sess_open = 1'b1;
                end
            end else if (b == CODE_STX) begin
                chk_phase = 1'b0;
                chk_seen  = '0;
                txt_cnt   = '0;
                rx_check  = '0;
                chk_bad   = 1'b0;
                run_sum   = cfg_seed_stx ? {8'h00, CODE_STX} : 16'h0000;
                r.frame_start = 1'b1;
            end else if (b == CODE_ETX) begin
                run_sum = sum_next(run_sum, CODE_ETX);
                if (cfg_check_en) begin
                    chk_phase = 1'b1;
                    chk_seen  = '0;
                    rx_check  = '0;
                    chk_bad   = 1'b0;
                end else begin
                    r.tx_code = TX_ACK;
                    frm_good  = 1'b1;
                end
            end else if (b == CODE_EOT) begin
                if (frm_good && sess_open) begin
                    r.status         = ST_ACCEPTED;
                    r.message_length = txt_cnt;
                end else begin
                    r.status = ST_REJECTED;
                end
                drop_message();
            end else if (chk_phase) begin
                // any byte other than the link codes counts as a check char; non-hex forces NAK
                if (b >= "0" && b <= "9") nib = 4'(b - "0");
                else if (b >= "a" && b <= "f") nib = 4'(b - "a" + 8'd10);
                else if (b >= "A" && b <= "F") nib = 4'(b - "A" + 8'd10);
                else begin
                    nib     = 4'h0;
                    chk_bad = 1'b1;
                end
                rx_check = {rx_check[11:0], nib};
                chk_seen = chk_seen + 3'd1;
                need     = cfg_two_char ? 3'd2 : 3'd4;
                if (chk_seen >= need) begin
                    mask      = cfg_two_char ? 16'h00FF : 16'hFFFF;
                    chk_phase = 1'b0;
                    if (!chk_bad && (run_sum & mask) == (rx_check & mask)) begin
                        r.tx_code = TX_ACK;
                        frm_good  = 1'b1;
                    end else begin
                        r.tx_code = TX_NAK;
                        chk_seen  = '0;
                        txt_cnt   = '0;
                    end
                end
            end else if (b >= CODE_PRINT_MIN) begin
                run_sum      = sum_next(run_sum, b);
                r.data_valid = 1'b1;
                r.data_byte  = b;
                r.data_index = txt_cnt[7:0];
                txt_cnt      = txt_cnt + 9'd1;
            end
            // overflow still reports the text byte of this item
            if (r.status == ST_RUNNING && txt_cnt >= MAX_FRAME) begin
                r.status = ST_OVERFLOW;
                drop_message();
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic void note_error(string msg);
        error_count++;
        if (error_count <= 10) $display("MISMATCH %s", msg);
    endfunction

    function automatic string show_result(t_result r);
        return $sformatf("tx=%0d dv=%0d byte=%02h idx=%0d fs=%0d st=%0d len=%0d",
                         r.tx_code, r.data_valid, r.data_byte, r.data_index,
                         r.frame_start, r.status, r.message_length);
    endfunction

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] nib, logic upper);
        if (nib < 4'd10) return 8'h30 + 8'(nib);
        return (upper ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
    endfunction

    // one input transfer; prediction is made at the accepting edge
    task automatic push_item(input logic kind, input logic [7:0] val, output t_result pred);
        int rest;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= val;
        do @(posedge i_clk); while (!s_axis_tready);
        pred = predict_reply(kind, val);
        outcome_q.push_back(pred);
        rest = src_calm ? 0 : pick_gap();
        if (rest > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (rest) @(posedge i_clk);
        end
    endtask

    // all four registers back to back; valid drops after the last transfer
    task automatic load_settings(input logic chk, input logic two, input logic stx,
                                 input logic [15:0] wl);
        logic [CFG_INDEX_W-1:0] idxs [4];
        logic [CFG_DATA_W-1:0]  vals [4];
        idxs = '{REG_CHECK_ENABLED, REG_TWO_CHAR_CHECK, REG_INCLUDE_STX, REG_WAIT_LIMIT};
        vals = '{16'(chk), 16'(two), 16'(stx), wl};
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idxs[k];
            i_cfg_data  <= vals[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (idxs[k])
                REG_CHECK_ENABLED:  cfg_check_en   = vals[k][0];
                REG_TWO_CHAR_CHECK: cfg_two_char   = vals[k][0];
                REG_INCLUDE_STX:    cfg_seed_stx   = vals[k][0];
                REG_WAIT_LIMIT:     cfg_wait_limit = vals[k];
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic plan_item(input logic kind, input logic [7:0] val);
        t_link_item it;
        it.kind = kind;
        it.val  = val;
        plan_q.push_back(it);
    endtask

    task automatic plan_tick();
        plan_item(REQ_TICK, 8'($urandom_range(0, 255)));
    endtask

    // Plans one message. Mostly well-formed (ENQ, STX, text, ETX, check chars,
    // EOT) with random content and occasional corruption; the rest is noise
    // or tick runs that drive the timeout.
    task automatic plan_message();
        int          pick;
        int          n;
        int          nchar;
        logic [15:0] s;
        logic [15:0] chk;
        logic [7:0]  b;
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            if ($urandom_range(0, 3) != 0) plan_item(REQ_BYTE, CODE_ENQ);
            plan_item(REQ_BYTE, CODE_STX);
            s = cfg_seed_stx ? {8'h00, CODE_STX} : 16'h0000;
            // a few frames run up to and past the frame size limit
            n = ($urandom_range(0, 99) < 3) ? $urandom_range(250, 258) : $urandom_range(0, 24);
            repeat (n) begin
                if ($urandom_range(0, 15) == 0) plan_tick();
                b = 8'($urandom_range(CODE_PRINT_MIN, 255));
                plan_item(REQ_BYTE, b);
                s = sum_next(s, b);
            end
            repeat (($urandom_range(0, 11) == 0) ? 2 : 1) begin
                plan_item(REQ_BYTE, CODE_ETX);
                s = sum_next(s, CODE_ETX);
            end
            if (cfg_check_en) begin
                nchar = cfg_two_char ? 2 : 4;
                chk   = s;
                if ($urandom_range(0, 7) == 0) chk[3:0] = chk[3:0] ^ 4'($urandom_range(1, 15));
                for (int k = nchar - 1; k >= 0; k--)
                    plan_item(REQ_BYTE, hex_char(chk[4*k +: 4], 1'($urandom_range(0, 1))));
            end
            repeat ($urandom_range(0, 2)) plan_tick();
            if ($urandom_range(0, 7) != 0) plan_item(REQ_BYTE, CODE_EOT);
        end else if (pick < 90) begin
            repeat ($urandom_range(1, 12))
                plan_item(1'($urandom_range(0, 3) == 0), 8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(1, (cfg_wait_limit < 40) ? int'(cfg_wait_limit) + 2 : 12))
                plan_tick();
        end
    endtask

    task automatic send_plan();
        t_link_item it;
        t_result    pred;
        while (plan_q.size() != 0) begin
            it = plan_q.pop_front();
            push_item(it.kind, it.val, pred);
            // ignored control bytes do not count toward the phase size
            if (it.kind == REQ_TICK || it.val >= CODE_PRINT_MIN ||
                (it.val >= CODE_STX && it.val <= CODE_ENQ))
                phase_items++;
        end
    endtask

    task automatic wait_drained();
        while (outcome_q.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_result pred;
        drop_message();
        // reset config: check on, two-char XOR, STX in sum, wait 300
        dir_rows = '{
            '{REQ_BYTE, CODE_EOT, 1'b1, TX_NONE, ST_REJECTED, 9'd0}, // EOT with no session
            '{REQ_TICK, 8'hFF,    1'b1, TX_NONE, ST_RUNNING,  9'd0},
            '{REQ_BYTE, CODE_ENQ, 1'b1, TX_ACK,  ST_RUNNING,  9'd0},
            '{REQ_BYTE, CODE_ENQ, 1'b1, TX_NONE, ST_RUNNING,  9'd0}, // repeated ENQ
            '{REQ_BYTE, 8'h01,    1'b1, TX_NONE, ST_RUNNING,  9'd0}, // stray control
            '{REQ_BYTE, 8'h1F,    1'b0, TX_NONE, ST_RUNNING,  9'd0},
            '{REQ_BYTE, CODE_STX, 1'b0, TX_NONE, ST_RUNNING,  9'd0},
            '{REQ_BYTE, "A",      1'b0, TX_NONE, ST_RUNNING,  9'd0},
            '{REQ_BYTE, 8'hFF,    1'b0, TX_NONE, ST_RUNNING,  9'd0},
            '{REQ_BYTE, 8'h20,    1'b0, TX_NONE, ST_RUNNING,  9'd0},
            '{REQ_BYTE, CODE_ETX, 1'b0, TX_NONE, ST_RUNNING,  9'd0},
            '{REQ_BYTE, "9",      1'b0, TX_NONE, ST_RUNNING,  9'd0},
            '{REQ_BYTE, "f",      1'b1, TX_ACK,  ST_RUNNING,  9'd0}, // sum 0x9F
            '{REQ_BYTE, CODE_EOT, 1'b1, TX_NONE, ST_ACCEPTED, 9'd3},
            '{REQ_BYTE, 8'h7E,    1'b0, TX_NONE, ST_RUNNING,  9'd0}, // text before ENQ
            '{REQ_BYTE, CODE_ENQ, 1'b1, TX_ACK,  ST_RUNNING,  9'd0},
            '{REQ_BYTE, CODE_ETX, 1'b0, TX_NONE, ST_RUNNING,  9'd0},
            '{REQ_BYTE, CODE_ETX, 1'b0, TX_NONE, ST_RUNNING,  9'd0}, // ETX again
            '{REQ_BYTE, "G",      1'b0, TX_NONE, ST_RUNNING,  9'd0}, // non-hex char
            '{REQ_BYTE, "0",      1'b1, TX_NAK,  ST_RUNNING,  9'd0},
            '{REQ_BYTE, CODE_ETX, 1'b0, TX_NONE, ST_RUNNING,  9'd0},
            '{REQ_BYTE, "7",      1'b0, TX_NONE, ST_RUNNING,  9'd0},
            '{REQ_BYTE, "D",      1'b1, TX_ACK,  ST_RUNNING,  9'd0}, // sum 0x7D
            '{REQ_BYTE, CODE_EOT, 1'b1, TX_NONE, ST_ACCEPTED, 9'd0}, // NAK cleared count
            '{REQ_TICK, 8'h00,    1'b0, TX_NONE, ST_RUNNING,  9'd0}
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < N_DIR; k++) begin
            push_item(dir_rows[k].kind, dir_rows[k].val, pred);
            if (dir_rows[k].typed && (pred.tx_code != dir_rows[k].tx ||
                pred.status != dir_rows[k].st || pred.message_length != dir_rows[k].len))
                note_error($sformatf("row %0d: exp tx=%0d st=%0d len=%0d, predicted %s",
                                     k, dir_rows[k].tx, dir_rows[k].st, dir_rows[k].len,
                                     show_result(pred)));
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            // sender pauses until the block has answered everything
            s_axis_tvalid <= 1'b0;
            wait_drained();
            repeat (4) @(posedge i_clk);
            case (ph)
                0: load_settings(1'b0, 1'b1, 1'b0, 16'd1);
                1: load_settings(1'b1, 1'b0, 1'b1, 16'hFFFF);
                2: load_settings(1'b1, 1'b1, 1'b0, 16'd3);
                3: load_settings(1'b0, 1'b0, 1'b1, WAIT_LIMIT_RST);
                default: load_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                       1'($urandom_range(0, 1)),
                                       ($urandom_range(0, 3) == 0) ?
                                           16'($urandom_range(1, 65535)) :
                                           16'($urandom_range(1, 40)));
            endcase
            src_calm = ($urandom_range(0, 3) == 0);
            snk_calm = ($urandom_range(0, 3) == 0);
            // long receiver hold while the sender keeps offering
            if (ph == 1) sink_hold_req = 1'b1;
            phase_items = 0;
            // stray check chars: may land in a check phase left open under the old mode
            repeat ($urandom_range(1, 5))
                plan_item(REQ_BYTE, hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
            send_plan();
            while (phase_items < PHASE_ITEMS) begin
                plan_message();
                send_plan();
            end
            // sometimes leave a frame waiting for its check chars
            if ($urandom_range(0, 1) == 1) begin
                plan_item(REQ_BYTE, CODE_STX);
                plan_item(REQ_BYTE, 8'($urandom_range(CODE_PRINT_MIN, 255)));
                plan_item(REQ_BYTE, CODE_ETX);
                send_plan();
            end
        end

        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (error_count == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result sink: random ready pattern plus one long hold
    // ------------------------------------------------------------------
    initial begin : sink
        int gap;
        forever begin
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (SINK_HOLD) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            gap = snk_calm ? 0 : pick_gap();
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Checker: each result transfer against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        string   diff;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.tx_code        = m_axis_tdata[1:0];
            got.data_byte      = m_axis_tdata[9:2];
            got.data_index     = m_axis_tdata[17:10];
            got.frame_start    = m_axis_tdata[18];
            got.status         = m_axis_tdata[21:19];
            got.message_length = m_axis_tdata[30:22];
            got.data_valid     = m_axis_tuser;
            if (outcome_q.size() == 0) begin
                note_error($sformatf("result %0d with none pending: %s",
                                     results_seen, show_result(got)));
            end else begin
                want = outcome_q.pop_front();
                diff = "";
                if (got.tx_code !== want.tx_code)               diff = {diff, " tx_code"};
                if (got.data_valid !== want.data_valid)         diff = {diff, " data_valid"};
                if (got.data_byte !== want.data_byte)           diff = {diff, " data_byte"};
                if (got.data_index !== want.data_index)         diff = {diff, " data_index"};
                if (got.frame_start !== want.frame_start)       diff = {diff, " frame_start"};
                if (got.status !== want.status)                 diff = {diff, " status"};
                if (got.message_length !== want.message_length) diff = {diff, " message_length"};
                if (diff != "")
                    note_error($sformatf("result %0d:%s exp %s got %s", results_seen, diff,
                                         show_result(want), show_result(got)));
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: no transfer on any channel for too long
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

// ===== framed_serial_message_receiver_top.f =====
sv/fsmr_pkg.sv
sv/fsmr_core.sv
sv/framed_serial_message_receiver_top.sv
sv/fsmr_checker.sv
test/tb.sv
